[sv/hpq_pkg.sv]
package hpq_pkg;

    // default number of stored values
    localparam int HPQ_DEPTH   = 1024;

    localparam int HPQ_VALUE_W = 32;
    localparam int HPQ_COUNT_W = 11;
    // node numbers (1-based) between cells, wide enough for the largest depth of 65536
    localparam int HPQ_NODE_W  = 17;
    // remaining-level counter carried by a down request
    localparam int HPQ_DEPTH_W = 5;

    // request function codes
    localparam logic [1:0] HPQ_FUNC_PUSH = 2'd0;
    localparam logic [1:0] HPQ_FUNC_POP  = 2'd1;
    localparam logic [1:0] HPQ_FUNC_PEEK = 2'd2;

    // down-going operations between levels
    localparam logic [1:0] HPQ_OP_INS   = 2'd0;
    localparam logic [1:0] HPQ_OP_FETCH = 2'd1;
    localparam logic [1:0] HPQ_OP_SIFT  = 2'd2;

    // up-going message kinds
    localparam logic HPQ_UP_WB  = 1'b0;
    localparam logic HPQ_UP_RET = 1'b1;

    typedef struct packed {
        logic [1:0]                     func;
        logic signed [HPQ_VALUE_W-1:0]  value;
    } t_hpq_in;

    typedef struct packed {
        logic signed [HPQ_VALUE_W-1:0]  top_value;
        logic [HPQ_COUNT_W-1:0]         count;
        logic                           empty_res;
        logic                           dropped;
    } t_hpq_out;

    // request handed from one level to the next one down
    typedef struct packed {
        logic                           valid;
        logic [1:0]                     op;
        logic signed [HPQ_VALUE_W-1:0]  value;
        logic [HPQ_NODE_W-1:0]          node;
        logic [HPQ_DEPTH_W-1:0]         depth;
        logic [HPQ_NODE_W-1:0]          cnt;
    } t_hpq_down;

    // message handed from one level to the one above
    typedef struct packed {
        logic                           valid;
        logic                           kind;
        logic signed [HPQ_VALUE_W-1:0]  value;
        logic [HPQ_NODE_W-1:0]          node;
    } t_hpq_up;

endpackage

[sv/hpq_cell.sv]
module hpq_cell #(
    parameter int LEVEL = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpq_pkg::t_hpq_down i_down,
    output hpq_pkg::t_hpq_down o_down,
    input  hpq_pkg::t_hpq_up   i_up,
    output hpq_pkg::t_hpq_up   o_up,
    output logic               o_done
);
    import hpq_pkg::*;

    // one row holds a sibling pair: left child in one array, right in the other
    localparam int RW   = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int ROWS = 1 << RW;
    localparam int NW   = HPQ_NODE_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic signed [HPQ_VALUE_W-1:0] r_mem_l [ROWS];
    logic signed [HPQ_VALUE_W-1:0] r_mem_r [ROWS];
    logic signed [HPQ_VALUE_W-1:0] r_rd_l;
    logic signed [HPQ_VALUE_W-1:0] r_rd_r;

    logic      r_state, n_state;
    t_hpq_down r_tok, n_tok;
    t_hpq_down r_down, n_down;
    t_hpq_up   r_up, n_up;
    logic      r_done, n_done;

    logic                          we;
    logic                          wsel;
    logic [RW-1:0]                 wrow;
    logic signed [HPQ_VALUE_W-1:0] wdata;
    logic                          rd_en;
    logic [RW-1:0]                 rd_row;

    logic [NW-1:0]                 j_in;
    logic [NW-1:0]                 j_tok;
    logic                          kids_in;
    logic signed [HPQ_VALUE_W-1:0] node_val;
    logic                          ins_win;
    logic                          right_ok;
    logic                          pick_r;
    logic signed [HPQ_VALUE_W-1:0] child_val;
    logic [NW-1:0]                 c_node;
    logic                          c_kids;

    // node on the insert or fetch path at this level
    assign j_in  = i_down.node >> i_down.depth;
    assign j_tok = r_tok.node >> r_tok.depth;

    // sift: does the parent have a left child at this level
    assign kids_in  = ({i_down.node, 1'b0} <= {1'b0, i_down.cnt});

    assign node_val = j_tok[0] ? r_rd_r : r_rd_l;
    assign ins_win  = r_tok.value > node_val;

    // larger child, right one on a tie
    assign right_ok  = ({r_tok.node, 1'b1} <= {1'b0, r_tok.cnt});
    assign pick_r    = right_ok && !(r_rd_l > r_rd_r);
    assign child_val = pick_r ? r_rd_r : r_rd_l;
    assign c_node    = {r_tok.node[NW-2:0], pick_r};
    assign c_kids    = ({c_node, 1'b0} <= {1'b0, r_tok.cnt});

    always_comb begin
        n_state = r_state;
        n_tok   = r_tok;
        n_down  = '0;
        n_up    = '0;
        n_done  = 1'b0;
        we      = 1'b0;
        wsel    = 1'b0;
        wrow    = '0;
        wdata   = '0;
        rd_en   = 1'b0;
        rd_row  = '0;

        // traffic from the level below
        if (i_up.valid) begin
            if (i_up.kind == HPQ_UP_WB) begin
                we    = 1'b1;
                wrow  = RW'(i_up.node >> 1);
                wsel  = i_up.node[0];
                wdata = i_up.value;
            end else begin
                n_up = i_up;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_down.valid) begin
                    case (i_down.op)
                        HPQ_OP_INS: begin
                            if (i_down.depth == '0) begin
                                we     = 1'b1;
                                wrow   = RW'(j_in >> 1);
                                wsel   = j_in[0];
                                wdata  = i_down.value;
                                n_done = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_row  = RW'(j_in >> 1);
                                n_tok   = i_down;
                                n_state = S_RD;
                            end
                        end
                        HPQ_OP_FETCH: begin
                            if (i_down.depth == '0) begin
                                rd_en   = 1'b1;
                                rd_row  = RW'(j_in >> 1);
                                n_tok   = i_down;
                                n_state = S_RD;
                            end else begin
                                n_down       = i_down;
                                n_down.depth = i_down.depth - 1'b1;
                            end
                        end
                        HPQ_OP_SIFT: begin
                            if (!kids_in) begin
                                n_up.valid = 1'b1;
                                n_up.kind  = HPQ_UP_WB;
                                n_up.value = i_down.value;
                                n_up.node  = i_down.node;
                                n_done     = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_row  = RW'(i_down.node);
                                n_tok   = i_down;
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                n_state = S_IDLE;
                case (r_tok.op)
                    HPQ_OP_INS: begin
                        n_down       = r_tok;
                        n_down.depth = r_tok.depth - 1'b1;
                        if (ins_win) begin
                            we           = 1'b1;
                            wrow         = RW'(j_tok >> 1);
                            wsel         = j_tok[0];
                            wdata        = r_tok.value;
                            n_down.value = node_val;
                        end
                    end
                    HPQ_OP_FETCH: begin
                        n_up.valid = 1'b1;
                        n_up.kind  = HPQ_UP_RET;
                        n_up.value = node_val;
                    end
                    HPQ_OP_SIFT: begin
                        n_up.valid = 1'b1;
                        n_up.kind  = HPQ_UP_WB;
                        n_up.node  = r_tok.node;
                        if (child_val > r_tok.value) begin
                            n_up.value = child_val;
                            if (c_kids) begin
                                n_down      = r_tok;
                                n_down.node = c_node;
                            end else begin
                                // promoted child has no children: entry settles here
                                we     = 1'b1;
                                wrow   = RW'(c_node >> 1);
                                wsel   = c_node[0];
                                wdata  = r_tok.value;
                                n_done = 1'b1;
                            end
                        end else begin
                            n_up.value = r_tok.value;
                            n_done     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            if (wsel) begin
                r_mem_r[wrow] <= wdata;
            end else begin
                r_mem_l[wrow] <= wdata;
            end
        end
        if (rd_en) begin
            r_rd_l <= r_mem_l[rd_row];
            r_rd_r <= r_mem_r[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_down  <= '0;
            r_up    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_down  <= n_down;
            r_up    <= n_up;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_down = r_down;
    assign o_up   = r_up;
    assign o_done = r_done;

endmodule

[sv/max_heap_priority_queue_top.sv]
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_in_req  (func, value)
// result    out        o_out_valid / i_out_ready  o_out_res (top_value, count, empty_res, dropped)
//
// one request at a time; peek, pop of an empty heap and refused push are answered without the level chain
// push: top-down insert; each level below the root keeps the larger value and passes the other down
// pop: the last entry is fetched down and back up the chain, then sifted down from the root
// a level cell reads its memory through a register before it compares or returns
// reset: synchronous, active low; clears the count, no memory clearing pass
// a finished result waits in the output register; a new request is taken meanwhile
module max_heap_priority_queue_top #(
    parameter int HEAP_DEPTH = hpq_pkg::HPQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hpq_pkg::t_hpq_in  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hpq_pkg::t_hpq_out o_out_res
);
    import hpq_pkg::*;

    // count width and number of heap levels; the root lives here, the rest in cells
    localparam int W      = $clog2(HEAP_DEPTH + 1);
    localparam int LEVELS = W;
    localparam int NW     = HPQ_NODE_W;
    localparam int DW     = HPQ_DEPTH_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [W-1:0]                  r_cnt, n_cnt;
    logic signed [HPQ_VALUE_W-1:0] r_top, n_top;
    logic                          r_drop, n_drop;
    t_hpq_down                     r_down, n_down;
    logic                          r_out_valid, n_out_valid;
    t_hpq_out                      r_out, n_out;

    // level chain: down links feed cell l from l-1, up links feed l-1 from l
    t_hpq_down             w_down [LEVELS];
    t_hpq_up               w_up   [1:LEVELS];
    logic [LEVELS-1:1]     w_done;
    logic                  any_done;

    logic                  accept;
    logic [W-1:0]          m_ins;
    logic                  push_full;

    // position of the highest set bit, i.e. the level of a 1-based node
    function automatic logic [DW-1:0] f_msb(input logic [W-1:0] x);
        logic [DW-1:0] r;
        r = '0;
        for (int b = 0; b < W; b++) begin
            if (x[b]) begin
                r = DW'(b);
            end
        end
        return r;
    endfunction

    assign w_down[0]      = r_down;
    assign w_up[LEVELS]   = '0;
    assign any_done       = |w_done;

    generate
        for (genvar l = 1; l < LEVELS; l++) begin : g_lvl
            hpq_cell #(
                .LEVEL (l)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_down  (w_down[l-1]),
                .o_down  (w_down[l]),
                .i_up    (w_up[l+1]),
                .o_up    (w_up[l]),
                .o_done  (w_done[l])
            );
        end
    endgenerate

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // 1-based node that a push fills
    assign m_ins      = r_cnt + 1'b1;
    assign push_full  = (r_cnt >= W'(HEAP_DEPTH));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_top       = r_top;
        n_drop      = r_drop;
        n_down      = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_drop  = 1'b0;
                    n_state = S_OUT;
                    unique case (i_in_req.func)
                        HPQ_FUNC_PUSH: begin
                            if (push_full) begin
                                // full store: refuse and flag
                                n_drop = 1'b1;
                            end else if (r_cnt == '0) begin
                                n_top = i_in_req.value;
                                n_cnt = W'(1);
                            end else begin
                                // top-down insert along the path to the new node
                                n_cnt        = m_ins;
                                n_down.valid = 1'b1;
                                n_down.op    = HPQ_OP_INS;
                                n_down.node  = NW'(m_ins);
                                n_down.depth = f_msb(m_ins) - 1'b1;
                                if (i_in_req.value > r_top) begin
                                    n_top        = i_in_req.value;
                                    n_down.value = r_top;
                                end else begin
                                    n_down.value = i_in_req.value;
                                end
                                n_state = S_WAIT;
                            end
                        end
                        HPQ_FUNC_POP: begin
                            if (r_cnt == W'(1)) begin
                                n_cnt = '0;
                            end else if (r_cnt != '0) begin
                                // fetch the last entry, then sift it down from the root
                                n_cnt        = r_cnt - 1'b1;
                                n_down.valid = 1'b1;
                                n_down.op    = HPQ_OP_FETCH;
                                n_down.node  = NW'(r_cnt);
                                n_down.depth = f_msb(r_cnt) - 1'b1;
                                n_state      = S_WAIT;
                            end
                        end
                        HPQ_FUNC_PEEK: ;
                        default: ;
                    endcase
                end
            end
            S_WAIT: begin
                if (w_up[1].valid) begin
                    if (w_up[1].kind == HPQ_UP_RET) begin
                        n_down.valid = 1'b1;
                        n_down.op    = HPQ_OP_SIFT;
                        n_down.value = w_up[1].value;
                        n_down.node  = NW'(1);
                        n_down.cnt   = NW'(r_cnt);
                    end else begin
                        // new root from the level below
                        n_top = w_up[1].value;
                    end
                end
                if (any_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.top_value = (r_cnt != '0) ? r_top : '0;
                    n_out.count     = HPQ_COUNT_W'(r_cnt);
                    n_out.empty_res = (r_cnt == '0);
                    n_out.dropped   = r_drop;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_down      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_drop      <= n_drop;
            r_down      <= n_down;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule
